@@ hw/rtl/poll_frame_parser_defines.svh @@
// assertion helpers for the poll frame parser
`ifndef POLL_FRAME_PARSER_DEFINES_SVH
`define POLL_FRAME_PARSER_DEFINES_SVH

// clocked assertion, off while reset is held
`define PFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check that holds whenever a result is offered
`define PFP_ASSERT_VALID(lbl, cond, msg) \
    `PFP_ASSERT(lbl, o_out_valid |-> (cond), msg)

`endif

@@ hw/rtl/pfp_pkg.sv @@
package pfp_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_OWN_UNIT_ID   = 2'd2,
        REG_MAX_PAYLOAD   = 2'd3
    } t_reg_idx;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_GOOD_MORE = 3'd0,
        ST_GOOD_LAST = 3'd1,
        ST_SHORT     = 3'd2,
        ST_HEADER    = 3'd3,
        ST_LENGTH    = 3'd4,
        ST_MISMATCH  = 3'd5,
        ST_UNIT      = 3'd6,
        ST_CHECKSUM  = 3'd7
    } t_status;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd10000;
    localparam logic [16:0] FRAME_OVERHEAD    = 17'd12;
    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
    localparam logic [15:0] LEN_FIELD_END     = 16'd4;
    localparam logic [15:0] PAYLOAD_START     = 16'd10;

    // byte positions of the fixed header
    localparam logic [15:0] POS_HEADER_FIRST  = 16'd0;
    localparam logic [15:0] POS_HEADER_SECOND = 16'd1;
    localparam logic [15:0] POS_LENGTH_LO     = 16'd2;
    localparam logic [15:0] POS_LENGTH_HI     = 16'd3;
    localparam logic [15:0] POS_UNIT_ID       = 16'd4;
    localparam logic [15:0] POS_TYPE          = 16'd5;
    localparam logic [15:0] POS_FRAME_NOW_LO  = 16'd6;
    localparam logic [15:0] POS_FRAME_NOW_HI  = 16'd7;
    localparam logic [15:0] POS_FRAME_END_LO  = 16'd8;
    localparam logic [15:0] POS_FRAME_END_HI  = 16'd9;

    typedef struct packed {
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [7:0]  own_unit_id;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic        restart;
        logic [7:0]  request_type;
        logic [15:0] current_frame;
        t_status     status;
    } t_result;

endpackage

@@ hw/rtl/pfp_cfg_regs.sv @@
module pfp_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfp_pkg::ADDR_W-1:0]  paddr,
    input  logic [pfp_pkg::DATA_W-1:0]  pwdata,
    output logic [pfp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output pfp_pkg::t_cfg               o_cfg
);
    import pfp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first  <= 8'd0;
            r_cfg.header_second <= 8'd0;
            r_cfg.own_unit_id   <= 8'd0;
            r_cfg.max_payload   <= MAX_PAYLOAD_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEADER_FIRST:  r_cfg.header_first  <= pwdata[7:0];
                REG_HEADER_SECOND: r_cfg.header_second <= pwdata[7:0];
                REG_OWN_UNIT_ID:   r_cfg.own_unit_id   <= pwdata[7:0];
                REG_MAX_PAYLOAD:   r_cfg.max_payload   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEADER_FIRST:  prdata = {{(DATA_W-8){1'b0}}, r_cfg.header_first};
            REG_HEADER_SECOND: prdata = {{(DATA_W-8){1'b0}}, r_cfg.header_second};
            REG_OWN_UNIT_ID:   prdata = {{(DATA_W-8){1'b0}}, r_cfg.own_unit_id};
            REG_MAX_PAYLOAD:   prdata = {{(DATA_W-16){1'b0}}, r_cfg.max_payload};
            default:           prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/pfp_parse.sv @@
module pfp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pfp_pkg::t_cfg    i_cfg,
    input  pfp_pkg::t_item   i_item,
    input  logic             i_advance,
    output pfp_pkg::t_result o_result,
    output logic             o_has_result
);
    import pfp_pkg::*;

    logic [15:0] r_pos;
    logic [15:0] r_len;
    logic [15:0] r_sum;
    logic [15:0] r_rsum;
    logic [15:0] r_frame_now;
    logic [15:0] r_frame_final;
    logic [7:0]  r_type;
    logic [1:0]  r_err;

    logic [15:0] n_len;
    logic [15:0] n_sum;
    logic [15:0] n_rsum;
    logic [15:0] n_frame_now;
    logic [15:0] n_frame_final;
    logic [7:0]  n_type;
    logic [1:0]  n_err;

    logic [7:0]  rx;
    logic [16:0] pos_p1;
    logic [16:0] pos_p2;
    logic [16:0] len_x;
    logic [16:0] max_len;
    logic [15:0] count;
    logic        is_payload;
    logic        len_bad;
    t_status     status;

    assign rx = i_item.rx_byte;

    always_comb begin
        n_len         = r_len;
        n_sum         = r_sum;
        n_rsum        = r_rsum;
        n_frame_now   = r_frame_now;
        n_frame_final = r_frame_final;
        n_type        = r_type;
        n_err         = r_err;

        case (r_pos)
            POS_HEADER_FIRST: begin
                if (rx != i_cfg.header_first) n_err[0] = 1'b1;
            end
            POS_HEADER_SECOND: begin
                if (rx != i_cfg.header_second) n_err[0] = 1'b1;
            end
            POS_LENGTH_LO:    n_len = {8'd0, rx};
            POS_LENGTH_HI:    n_len = {rx, r_len[7:0]};
            POS_UNIT_ID: begin
                if (rx != i_cfg.own_unit_id) n_err[1] = 1'b1;
            end
            POS_TYPE:         n_type = rx;
            POS_FRAME_NOW_LO: n_frame_now = {8'd0, rx};
            POS_FRAME_NOW_HI: n_frame_now = {rx, r_frame_now[7:0]};
            POS_FRAME_END_LO: n_frame_final = {8'd0, rx};
            POS_FRAME_END_HI: n_frame_final = {rx, r_frame_final[7:0]};
            default: ;
        endcase

        pos_p1 = {1'b0, r_pos} + 17'd1;
        pos_p2 = {1'b0, r_pos} + 17'd2;
        len_x  = {1'b0, r_len};

        // sum covers everything before the checksum field
        if (r_pos < LEN_FIELD_END || pos_p2 < len_x) begin
            n_sum = r_sum + {8'd0, rx};
        end
        if (r_pos >= PAYLOAD_START && r_len >= FRAME_OVERHEAD[15:0]) begin
            if (pos_p2 == len_x) begin
                n_rsum = {r_rsum[15:8], rx};
            end else if (pos_p1 == len_x) begin
                n_rsum = {rx, r_rsum[7:0]};
            end
        end
        is_payload = (r_pos >= PAYLOAD_START) && (pos_p2 < len_x);

        // saturating byte count
        count = (r_pos == COUNT_MAX) ? COUNT_MAX : pos_p1[15:0];

        max_len = {1'b0, i_cfg.max_payload} + FRAME_OVERHEAD;
        len_bad = (n_len < FRAME_OVERHEAD[15:0]) || ({1'b0, n_len} > max_len);

        if (count < LEN_FIELD_END) begin
            status = ST_SHORT;
        end else if (n_err[0]) begin
            status = ST_HEADER;
        end else if (len_bad) begin
            status = ST_LENGTH;
        end else if (count != n_len) begin
            status = ST_MISMATCH;
        end else if (n_err[1]) begin
            status = ST_UNIT;
        end else if (n_rsum != n_sum) begin
            status = ST_CHECKSUM;
        end else if (n_frame_now == n_frame_final) begin
            status = ST_GOOD_LAST;
        end else begin
            status = ST_GOOD_MORE;
        end

        o_has_result           = i_item.end_of_packet || is_payload;
        o_result.restart       = (n_frame_now == 16'd0);
        o_result.request_type  = n_type;
        o_result.current_frame = n_frame_now;
        if (i_item.end_of_packet) begin
            o_result.kind         = KIND_STATUS;
            o_result.payload_byte = 8'd0;
            o_result.status       = status;
        end else begin
            o_result.kind         = KIND_PAYLOAD;
            o_result.payload_byte = rx;
            o_result.status       = ST_GOOD_MORE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.end_of_packet)) begin
            r_pos         <= 16'd0;
            r_len         <= 16'd0;
            r_sum         <= 16'd0;
            r_rsum        <= 16'd0;
            r_frame_now   <= 16'd0;
            r_frame_final <= 16'd0;
            r_type        <= 8'd0;
            r_err         <= 2'd0;
        end else if (i_advance) begin
            r_pos         <= count;
            r_len         <= n_len;
            r_sum         <= n_sum;
            r_rsum        <= n_rsum;
            r_frame_now   <= n_frame_now;
            r_frame_final <= n_frame_final;
            r_type        <= n_type;
            r_err         <= n_err;
        end
    end

endmodule

@@ hw/rtl/poll_frame_parser.sv @@
// Poll frame parser: takes one received byte per transfer and checks the packet as it
// streams, giving a payload result for each payload byte and one status result on the
// byte marked end of packet. It sustains one byte per clock while the output is not
// stalled; a result passes through the input register and then the result register
// around the single stage of parse logic. The input stalls only while a byte that
// makes a result sits in the input register and the held result is stalled. Payload
// bytes are usable only if the closing status is good (0 or 1).
module poll_frame_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_end_of_packet,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_result_kind,
    output logic [7:0]                  o_payload_byte,
    output logic                        o_restart_reassembly,
    output logic [7:0]                  o_request_type,
    output logic [15:0]                 o_current_frame,
    output logic [2:0]                  o_packet_status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfp_pkg::ADDR_W-1:0]  paddr,
    input  logic [pfp_pkg::DATA_W-1:0]  pwdata,
    output logic [pfp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import pfp_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result result;
    logic    has_result;
    logic    out_blocked;
    logic    advance;
    logic    in_take;

    pfp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pfp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (r_in),
        .i_advance    (advance),
        .o_result     (result),
        .o_has_result (has_result)
    );

    assign out_blocked = r_out_valid && i_out_stall;
    assign advance     = r_in_valid && (!out_blocked || !has_result);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.rx_byte       <= i_rx_byte;
            r_in.end_of_packet <= i_end_of_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out <= result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_result_kind        = r_out.kind;
    assign o_payload_byte       = r_out.payload_byte;
    assign o_restart_reassembly = r_out.restart;
    assign o_request_type       = r_out.request_type;
    assign o_current_frame      = r_out.current_frame;
    assign o_packet_status      = r_out.status;

endmodule

@@ hw/rtl/pfp_checker.sv @@
`include "poll_frame_parser_defines.svh"

module pfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_result_kind,
    input logic [7:0]  o_payload_byte,
    input logic        o_restart_reassembly,
    input logic [15:0] o_current_frame,
    input logic [2:0]  o_packet_status
);
    import pfp_pkg::*;

    // a stalled result stays offered and unchanged
    `PFP_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_payload_byte) && $stable(o_packet_status) && $stable(o_current_frame), "stalled result changed")

    `PFP_ASSERT_VALID(a_status_no_data, o_result_kind != KIND_STATUS || o_payload_byte == 8'd0, "status transfer carries payload data")

    `PFP_ASSERT_VALID(a_payload_no_status, o_result_kind != KIND_PAYLOAD || o_packet_status == ST_GOOD_MORE, "payload transfer carries a status")

    `PFP_ASSERT_VALID(a_restart_frame, o_restart_reassembly == (o_current_frame == 16'd0), "restart flag disagrees with frame index")

endmodule

bind poll_frame_parser pfp_checker u_pfp_checker (.*);
